FILE: design/atim_pkg.sv
package atim_pkg;

  localparam int unsigned MAG_W = 32;
  localparam int unsigned SCL_W = 24;
  localparam int unsigned REM_W = SCL_W + 1;
  localparam int unsigned Q_W   = 9;
  localparam int unsigned ANG_W = 14;
  localparam int unsigned TAB_W = 10;
  localparam int unsigned LATENCY = Q_W + 3;

  localparam logic [MAG_W-1:0] MAG_LIMIT = 32'd32000;
  localparam logic signed [ANG_W-1:0] MRAD_HALF_PI = 14'sd1571;
  localparam logic signed [ANG_W-1:0] MRAD_PI      = 14'sd3142;
  localparam logic signed [ANG_W-1:0] MRAD_TWO_PI  = 14'sd6283;

  typedef struct packed {
    logic yneg;
    logic xneg;
    logic yzero;
    logic xzero;
    logic swap;
  } flags_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [SCL_W-1:0] dvs;
    logic [Q_W-1:0]   quo;
    flags_t           flags;
  } cell_t;

  function automatic logic [TAB_W-1:0] octant_entry(input logic [4:0] idx);
    logic [TAB_W-1:0] v;
    case (idx)
      5'd0:    v = 10'd0;
      5'd1:    v = 10'd62;
      5'd2:    v = 10'd124;
      5'd3:    v = 10'd185;
      5'd4:    v = 10'd245;
      5'd5:    v = 10'd303;
      5'd6:    v = 10'd359;
      5'd7:    v = 10'd412;
      5'd8:    v = 10'd464;
      5'd9:    v = 10'd512;
      5'd10:   v = 10'd559;
      5'd11:   v = 10'd602;
      5'd12:   v = 10'd644;
      5'd13:   v = 10'd682;
      5'd14:   v = 10'd719;
      5'd15:   v = 10'd753;
      default: v = 10'd785;
    endcase
    return v;
  endfunction

endpackage

FILE: design/atim_front.sv
module atim_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  input  logic signed [atim_pkg::MAG_W-1:0] y_value_i,
  input  logic signed [atim_pkg::MAG_W-1:0] x_value_i,
  output logic                            valid_o,
  output atim_pkg::cell_t                 cell_o
);
  import atim_pkg::*;

  logic             v1_q;
  logic [MAG_W-1:0] ay_q, ax_q;
  flags_t           fl_q;

  logic             scale;
  logic [SCL_W-1:0] sy, sx;
  cell_t            cell_d, cell_q;
  logic             v2_q;

  // stage one: magnitudes and sign/zero flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ay_q       <= y_value_i[MAG_W-1] ? (MAG_W'(0) - y_value_i) : y_value_i;
    ax_q       <= x_value_i[MAG_W-1] ? (MAG_W'(0) - x_value_i) : x_value_i;
    fl_q.yneg  <= y_value_i[MAG_W-1];
    fl_q.xneg  <= x_value_i[MAG_W-1];
    fl_q.yzero <= (y_value_i == '0);
    fl_q.xzero <= (x_value_i == '0);
    fl_q.swap  <= 1'b0;
  end

  // stage two: scale down large vectors, put the smaller one on top
  always_comb begin
    logic [MAG_W-1:0] ty, tx;
    scale = (ay_q > MAG_LIMIT) || (ax_q > MAG_LIMIT);
    ty    = scale ? (ay_q >> 8) : ay_q;
    tx    = scale ? (ax_q >> 8) : ax_q;
    sy    = ty[SCL_W-1:0];
    sx    = tx[SCL_W-1:0];
    cell_d            = '0;
    cell_d.flags      = fl_q;
    cell_d.flags.swap = (sy > sx);
    cell_d.rem        = {1'b0, (sy > sx) ? sx : sy};
    cell_d.dvs        = (sy > sx) ? sy : sx;
    cell_d.quo        = '0;
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  assign valid_o = v2_q;
  assign cell_o  = cell_q;

endmodule

FILE: design/atim_div_cell.sv
module atim_div_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  atim_pkg::cell_t cell_i,
  output logic            valid_o,
  output atim_pkg::cell_t cell_o
);
  import atim_pkg::*;

  logic             ge;
  logic [REM_W-1:0] diff;
  cell_t            cell_d, cell_q;
  logic             valid_q;

  // one quotient bit per cell; remainder leaves already doubled
  always_comb begin
    ge         = (cell_i.rem >= {1'b0, cell_i.dvs});
    diff       = cell_i.rem - {1'b0, cell_i.dvs};
    cell_d     = cell_i;
    cell_d.rem = ge ? {diff[SCL_W-1:0], 1'b0} : {cell_i.rem[SCL_W-1:0], 1'b0};
    cell_d.quo = {cell_i.quo[Q_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  assign valid_o = valid_q;
  assign cell_o  = cell_q;

endmodule

FILE: design/atim_back.sv
module atim_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  atim_pkg::cell_t                   cell_i,
  output logic                              done_o,
  output logic signed [atim_pkg::ANG_W-1:0] angle_o
);
  import atim_pkg::*;

  logic [TAB_W-1:0]        lo, hi, step, f;
  logic [TAB_W-1:0]        prod;
  logic signed [ANG_W-1:0] a_oct, ang_d, ang_q;
  logic                    done_q;

  always_comb begin
    lo    = octant_entry({1'b0, cell_i.quo[7:4]});
    hi    = octant_entry({1'b0, cell_i.quo[7:4]} + 5'd1);
    step  = hi - lo;
    prod  = {4'd0, step[5:0]} * {6'd0, cell_i.quo[3:0]};
    // ratio of exactly one reads the last entry
    f     = cell_i.quo[Q_W-1] ? octant_entry(5'd16) : (lo + {4'd0, prod[TAB_W-1:4]});
    a_oct = cell_i.flags.swap ? (MRAD_HALF_PI - $signed({4'd0, f}))
                              : $signed({4'd0, f});
    if (cell_i.flags.xzero) begin
      ang_d = cell_i.flags.yneg ? -MRAD_HALF_PI : MRAD_HALF_PI;
    end else if (cell_i.flags.yzero) begin
      ang_d = cell_i.flags.xneg ? MRAD_PI : '0;
    end else if (cell_i.flags.xneg) begin
      ang_d = cell_i.flags.yneg ? (MRAD_PI + a_oct) : (MRAD_PI - a_oct);
    end else if (cell_i.flags.yneg) begin
      ang_d = MRAD_TWO_PI - a_oct;
    end else begin
      ang_d = a_oct;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ang_q <= ang_d;
  end

  assign done_o  = done_q;
  assign angle_o = ang_q;

endmodule

FILE: design/atan2_table_interp_milliradian.sv
// channel  | direction | handshake          | payload
// ---------+-----------+--------------------+--------------------------
// command  | in        | start_i, busy_o    | y_value_i, x_value_i
// result   | out       | done_o (strobe)    | angle_mrad_o
//
// An item is taken on every cycle with start_i high; busy_o stays low.
// Each item passes through the front stages of magnitude and scaling,
// nine divider cells (one quotient bit each), and the table interpolation
// and quadrant fold stage. Results leave in order, one per cycle.
// Reset clears only the valid bits along the pipe; no result is stalled.
module atan2_table_interp_milliradian (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic signed [atim_pkg::MAG_W-1:0] y_value_i,
  input  logic signed [atim_pkg::MAG_W-1:0] x_value_i,
  output logic                              done_o,
  output logic signed [atim_pkg::ANG_W-1:0] angle_mrad_o
);
  import atim_pkg::*;

  logic  vld [Q_W+1];
  cell_t cel [Q_W+1];

  assign busy_o = 1'b0;

  atim_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (start_i),
    .y_value_i (y_value_i),
    .x_value_i (x_value_i),
    .valid_o   (vld[0]),
    .cell_o    (cel[0])
  );

  for (genvar i = 0; i < Q_W; i++) begin : g_cell
    atim_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld[i]),
      .cell_i  (cel[i]),
      .valid_o (vld[i+1]),
      .cell_o  (cel[i+1])
    );
  end

  atim_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld[Q_W]),
    .cell_i  (cel[Q_W]),
    .done_o  (done_o),
    .angle_o (angle_mrad_o)
  );

`ifndef SYNTH
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LATENCY done_o)
    else $error("item taken but no result after pipeline latency");

  a_no_phantom : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, LATENCY))
    else $error("result without a matching item");

  a_neg_only_axis : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && angle_mrad_o[ANG_W-1]) |-> (angle_mrad_o == -MRAD_HALF_PI))
    else $error("negative angle other than the negative y axis");

  a_upper : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (angle_mrad_o <= MRAD_TWO_PI))
    else $error("angle above two pi");
`endif

endmodule
